### rtl/core/cau_pkg.sv
package cau_pkg;

  localparam int PART_WIDTH = 16;

  typedef enum logic [1:0] {
    CAU_ADD = 2'd0,
    CAU_SUB = 2'd1,
    CAU_MUL = 2'd2,
    CAU_DIV = 2'd3
  } cau_kind_t;

  typedef struct packed {
    cau_kind_t                    kind;
    logic signed [PART_WIDTH-1:0] a_re;
    logic signed [PART_WIDTH-1:0] a_im;
    logic signed [PART_WIDTH-1:0] b_re;
    logic signed [PART_WIDTH-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [PART_WIDTH-1:0] res_re;
    logic signed [PART_WIDTH-1:0] res_im;
    logic                         div_zero;
    logic                         overflow;
  } cau_out_t;

endpackage

### rtl/core/complex_arith_unit_top.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall   | cau_in_t  (kind, a_re, a_im, b_re, b_im)
// out_    | output    | out_valid/out_stall | cau_out_t (res_re, res_im, div_zero, overflow)
//
// One transaction per cycle sustained while out_stall stays low; operands are Q8.8 by default,
// and the restoring divider resolves one quotient bit per stage.
// Stages: products, sums, magnitudes, divide setup, PART_WIDTH divide steps, pack.
// Synchronous active-low reset clears the valid bits only.
// Stall back-pressure fills empty stages first, so inputs are taken while a result waits.
module complex_arith_unit_top
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cau_out_t out_data
);

  localparam int W  = PART_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int MW = 2 * W;
  localparam int DW = 2 * W;
  localparam int VW = 2 * W;
  localparam int CW = 3 * W + F;
  localparam logic [VW-1:0] NEG_MAG = VW'(1) << (W - 1);
  localparam logic [VW-1:0] POS_MAG = NEG_MAG - VW'(1);

  function automatic logic [W:0] pack_part(input logic neg, input logic big,
                                           input logic [VW-1:0] val);
    logic         sat;
    logic [W-1:0] res;
    sat = big || (neg ? (val > NEG_MAG) : (val > POS_MAG));
    if (neg) begin
      res = sat ? {1'b1, {(W-1){1'b0}}} : -val[W-1:0];
    end else begin
      res = sat ? {1'b0, {(W-1){1'b1}}} : val[W-1:0];
    end
    return {sat, res};
  endfunction

  // stage 1: products and short sums
  logic               v1_r;
  cau_kind_t          kind1_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [W:0]  as_re_r, as_im_r;
  logic signed [W:0]  as_re_nxt, as_im_nxt;

  // stage 2: wide sums
  logic               v2_r;
  cau_kind_t          kind2_r;
  logic signed [SW-1:0] s_re_r, s_im_r, s_re_nxt, s_im_nxt;
  logic [DW-1:0]      den2_r;

  // stage 3: sign and magnitude
  logic               v3_r;
  cau_kind_t          kind3_r;
  logic               neg_re3_r, neg_im3_r;
  logic [MW-1:0]      mag_re3_r, mag_im3_r;
  logic [DW-1:0]      den3_r;

  // divide stages
  logic          d_v_r      [W+1];
  logic          d_div_r    [W+1];
  logic          d_dz_r     [W+1];
  logic          d_neg_re_r [W+1];
  logic          d_neg_im_r [W+1];
  logic          d_big_re_r [W+1];
  logic          d_big_im_r [W+1];
  logic [VW-1:0] d_val_re_r [W+1];
  logic [VW-1:0] d_val_im_r [W+1];
  logic [CW-1:0] d_rem_re_r [W];
  logic [CW-1:0] d_rem_im_r [W];
  logic [DW-1:0] d_den_r    [W];
  logic [VW-1:0] val_re0_nxt, val_im0_nxt;
  logic [CW-1:0] rem_re0_nxt, rem_im0_nxt;

  logic     out_v_r;
  cau_out_t out_r;
  cau_out_t out_nxt;
  logic [W:0] pk_re, pk_im;

  logic       out_adv, s1_adv, s2_adv, s3_adv;
  logic [W:0] d_adv;

  assign out_adv  = !out_v_r || !out_stall;
  assign d_adv[W] = !d_v_r[W] || out_adv;
  for (genvar j = 0; j < W; j++) begin : g_adv
    assign d_adv[j] = !d_v_r[j] || d_adv[j+1];
  end
  assign s3_adv   = !v3_r || d_adv[0];
  assign s2_adv   = !v2_r || s3_adv;
  assign s1_adv   = !v1_r || s2_adv;
  assign in_stall = !s1_adv;

  // stage 1
  always_comb begin
    if (in_data.kind == CAU_SUB) begin
      as_re_nxt = (W+1)'(in_data.a_re) - (W+1)'(in_data.b_re);
      as_im_nxt = (W+1)'(in_data.a_im) - (W+1)'(in_data.b_im);
    end else begin
      as_re_nxt = (W+1)'(in_data.a_re) + (W+1)'(in_data.b_re);
      as_im_nxt = (W+1)'(in_data.a_im) + (W+1)'(in_data.b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      kind1_r <= in_data.kind;
      p_rr_r  <= in_data.a_re * in_data.b_re;
      p_ii_r  <= in_data.a_im * in_data.b_im;
      p_ri_r  <= in_data.a_re * in_data.b_im;
      p_ir_r  <= in_data.a_im * in_data.b_re;
      p_bb_r  <= in_data.b_re * in_data.b_re;
      p_cc_r  <= in_data.b_im * in_data.b_im;
      as_re_r <= as_re_nxt;
      as_im_r <= as_im_nxt;
    end
  end

  // stage 2
  always_comb begin
    unique case (kind1_r)
      CAU_ADD, CAU_SUB: begin
        s_re_nxt = SW'(as_re_r);
        s_im_nxt = SW'(as_im_r);
      end
      CAU_MUL: begin
        s_re_nxt = SW'(p_rr_r) - SW'(p_ii_r);
        s_im_nxt = SW'(p_ri_r) + SW'(p_ir_r);
      end
      CAU_DIV: begin
        s_re_nxt = SW'(p_rr_r) + SW'(p_ii_r);
        s_im_nxt = SW'(p_ir_r) - SW'(p_ri_r);
      end
      default: begin
        s_re_nxt = '0;
        s_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && v1_r) begin
      kind2_r <= kind1_r;
      s_re_r  <= s_re_nxt;
      s_im_r  <= s_im_nxt;
      den2_r  <= $unsigned(p_bb_r) + $unsigned(p_cc_r);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (s3_adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && v2_r) begin
      kind3_r   <= kind2_r;
      neg_re3_r <= s_re_r[SW-1];
      neg_im3_r <= s_im_r[SW-1];
      mag_re3_r <= s_re_r[SW-1] ? MW'(-s_re_r) : MW'(s_re_r);
      mag_im3_r <= s_im_r[SW-1] ? MW'(-s_im_r) : MW'(s_im_r);
      den3_r    <= den2_r;
    end
  end

  // divide setup
  assign rem_re0_nxt = CW'(mag_re3_r) << F;
  assign rem_im0_nxt = CW'(mag_im3_r) << F;

  always_comb begin
    unique case (kind3_r)
      CAU_ADD, CAU_SUB: begin
        val_re0_nxt = mag_re3_r;
        val_im0_nxt = mag_im3_r;
      end
      CAU_MUL: begin
        val_re0_nxt = mag_re3_r >> F;
        val_im0_nxt = mag_im3_r >> F;
      end
      CAU_DIV: begin
        val_re0_nxt = '0;
        val_im0_nxt = '0;
      end
      default: begin
        val_re0_nxt = '0;
        val_im0_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r[0] <= 1'b0;
    end else if (d_adv[0]) begin
      d_v_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_adv[0] && v3_r) begin
      d_div_r[0]    <= kind3_r == CAU_DIV;
      d_dz_r[0]     <= (kind3_r == CAU_DIV) && (den3_r == '0);
      d_neg_re_r[0] <= neg_re3_r;
      d_neg_im_r[0] <= neg_im3_r;
      d_big_re_r[0] <= (kind3_r == CAU_DIV) && (rem_re0_nxt >= (CW'(den3_r) << W));
      d_big_im_r[0] <= (kind3_r == CAU_DIV) && (rem_im0_nxt >= (CW'(den3_r) << W));
      d_val_re_r[0] <= val_re0_nxt;
      d_val_im_r[0] <= val_im0_nxt;
      d_rem_re_r[0] <= rem_re0_nxt;
      d_rem_im_r[0] <= rem_im0_nxt;
      d_den_r[0]    <= den3_r;
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int SH = W - 1 - j;
    logic [CW-1:0] trial;
    logic          take_re, take_im;

    assign trial   = CW'(d_den_r[j]) << SH;
    assign take_re = d_div_r[j] && (d_rem_re_r[j] >= trial);
    assign take_im = d_div_r[j] && (d_rem_im_r[j] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[j+1] <= 1'b0;
      end else if (d_adv[j+1]) begin
        d_v_r[j+1] <= d_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (d_adv[j+1] && d_v_r[j]) begin
        d_div_r[j+1]    <= d_div_r[j];
        d_dz_r[j+1]     <= d_dz_r[j];
        d_neg_re_r[j+1] <= d_neg_re_r[j];
        d_neg_im_r[j+1] <= d_neg_im_r[j];
        d_big_re_r[j+1] <= d_big_re_r[j];
        d_big_im_r[j+1] <= d_big_im_r[j];
        d_val_re_r[j+1] <= d_div_r[j] ? {d_val_re_r[j][VW-2:0], take_re} : d_val_re_r[j];
        d_val_im_r[j+1] <= d_div_r[j] ? {d_val_im_r[j][VW-2:0], take_im} : d_val_im_r[j];
      end
    end

    if (j < W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (d_adv[j+1] && d_v_r[j]) begin
          d_rem_re_r[j+1] <= take_re ? d_rem_re_r[j] - trial : d_rem_re_r[j];
          d_rem_im_r[j+1] <= take_im ? d_rem_im_r[j] - trial : d_rem_im_r[j];
          d_den_r[j+1]    <= d_den_r[j];
        end
      end
    end
  end

  // pack and saturate
  always_comb begin
    pk_re = pack_part(d_neg_re_r[W], d_big_re_r[W], d_val_re_r[W]);
    pk_im = pack_part(d_neg_im_r[W], d_big_im_r[W], d_val_im_r[W]);
    if (d_dz_r[W]) begin
      out_nxt.res_re   = '0;
      out_nxt.res_im   = '0;
      out_nxt.div_zero = 1'b1;
      out_nxt.overflow = 1'b0;
    end else begin
      out_nxt.res_re   = pk_re[W-1:0];
      out_nxt.res_im   = pk_im[W-1:0];
      out_nxt.div_zero = 1'b0;
      out_nxt.overflow = pk_re[W] || pk_im[W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= d_v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && d_v_r[W]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### rtl/core/cau_checker.sv
module cau_props
  import cau_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input cau_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |->
      out_data.res_re == '0 && out_data.res_im == '0 && !out_data.overflow)
    else $error("divide-by-zero result not clean");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with output empty");

endmodule

bind complex_arith_unit_top cau_props u_cau_props (.*);

### tb/cau_checker.sv
module cau_checker
  import cau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  cau_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  cau_out_t out_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam longint POS_MAX = (64'sd1 <<< (PART_WIDTH - 1)) - 1;
  localparam longint NEG_MAG = 64'sd1 <<< (PART_WIDTH - 1);

  cau_out_t result_q[$];

  function automatic logic [PART_WIDTH-1:0] clamp_part(input bit neg, input longint mag,
                                                       inout bit ovf);
    longint v;
    if (neg) begin
      if (mag > NEG_MAG) begin
        mag = NEG_MAG;
        ovf = 1'b1;
      end
      v = -mag;
    end else begin
      if (mag > POS_MAX) begin
        mag = POS_MAX;
        ovf = 1'b1;
      end
      v = mag;
    end
    return v[PART_WIDTH-1:0];
  endfunction

  function automatic longint frac_quot(input longint num, input longint den);
    longint q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < FRAC; i++) begin
      if (q > NEG_MAG) return NEG_MAG + 1;
      r = r <<< 1;
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic cau_out_t complex_result(input cau_in_t t);
    cau_out_t o;
    longint ar, ai, br, bi, r, m, den;
    bit ovf;
    ar = longint'(t.a_re);
    ai = longint'(t.a_im);
    br = longint'(t.b_re);
    bi = longint'(t.b_im);
    ovf = 1'b0;
    o = '0;
    case (t.kind)
      CAU_ADD, CAU_SUB: begin
        r = (t.kind == CAU_ADD) ? ar + br : ar - br;
        m = (t.kind == CAU_ADD) ? ai + bi : ai - bi;
        o.res_re = clamp_part(r < 0, r < 0 ? -r : r, ovf);
        o.res_im = clamp_part(m < 0, m < 0 ? -m : m, ovf);
      end
      CAU_MUL: begin
        r = ar * br - ai * bi;
        m = ar * bi + ai * br;
        o.res_re = clamp_part(r < 0, (r < 0 ? -r : r) >>> FRAC, ovf);
        o.res_im = clamp_part(m < 0, (m < 0 ? -m : m) >>> FRAC, ovf);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.div_zero = 1'b1;
        end else begin
          r = ar * br + ai * bi;
          m = ai * br - ar * bi;
          o.res_re = clamp_part(r < 0, frac_quot(r < 0 ? -r : r, den), ovf);
          o.res_im = clamp_part(m < 0, frac_quot(m < 0 ? -m : m, den), ovf);
        end
      end
    endcase
    o.overflow = ovf;
    return o;
  endfunction

  assign pending = result_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    cau_out_t exp_res;
    if (rst_n) begin
      if (in_valid && !in_stall) result_q.push_back(complex_result(in_data));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("unexpected transaction %h", out_data);
          fail_count = fail_count + 1;
        end else begin
          exp_res = result_q.pop_front();
          if (out_data.res_re !== exp_res.res_re) begin
            $error("res_re expected %h got %h", exp_res.res_re, out_data.res_re);
            fail_count = fail_count + 1;
          end
          if (out_data.res_im !== exp_res.res_im) begin
            $error("res_im expected %h got %h", exp_res.res_im, out_data.res_im);
            fail_count = fail_count + 1;
          end
          if (out_data.div_zero !== exp_res.div_zero) begin
            $error("div_zero expected %b got %b", exp_res.div_zero, out_data.div_zero);
            fail_count = fail_count + 1;
          end
          if (out_data.overflow !== exp_res.overflow) begin
            $error("overflow expected %b got %b", exp_res.overflow, out_data.overflow);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/testbench.sv
module testbench;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = PART_WIDTH + 5;
  localparam int IDLE_LIMIT = 2000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  cau_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  cau_out_t out_data;
  int       fail_count;
  int       pending;

  cau_in_t  directed_q[$];
  int       idle_cycles;

  complex_arith_unit_top DUT (.*);

  cau_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [PART_WIDTH-1:0] pick_part();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return '0;
      3: return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic cau_in_t random_operands();
    cau_in_t t;
    t.kind = cau_kind_t'($urandom_range(0, 3));
    t.a_re = pick_part();
    t.a_im = pick_part();
    t.b_re = pick_part();
    t.b_im = pick_part();
    if (t.kind == CAU_DIV && $urandom_range(0, 9) == 0) begin
      t.b_re = '0;
      t.b_im = '0;
    end
    return t;
  endfunction

  task automatic send(input cau_in_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 3))
        0: out_stall <= 1'b1;
        1: out_stall <= ($urandom_range(0, 4) == 0);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int burst;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < 4; k++) begin
      directed_q.push_back('{cau_kind_t'(k), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
      directed_q.push_back('{cau_kind_t'(k), 16'h8000, 16'h8000, 16'h8000, 16'h8000});
      directed_q.push_back('{cau_kind_t'(k), 16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
      directed_q.push_back('{cau_kind_t'(k), 16'hff00, 16'h0180, 16'h0100, 16'hfe80});
      directed_q.push_back('{cau_kind_t'(k), 16'h0000, 16'h0000, 16'h0001, 16'hffff});
    end
    directed_q.push_back('{CAU_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000});
    directed_q.push_back('{CAU_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'h0000});
    directed_q.push_back('{CAU_DIV, 16'h7fff, 16'h0000, 16'h0001, 16'h0000});
    directed_q.push_back('{CAU_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000});

    foreach (directed_q[i]) send(directed_q[i]);

    for (int n = 0; n < 1000;) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst && n < 1000; j++, n++) send(random_operands());
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (LATENCY * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/cau_pkg.sv
rtl/core/complex_arith_unit_top.sv
rtl/core/cau_checker.sv
tb/cau_checker.sv
tb/testbench.sv
